@@ design/segscan_pkg.sv @@
// Package for the multiplexed seven-segment field display scanner.
// Holds the command and status codes, field widths and the character decoder.
// No dependencies.
package segscan_pkg;

  localparam int CMD_W   = 3;
  localparam int FSEL_W  = 2;
  localparam int POS_W   = 4;
  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 4;
  localparam int STAT_W  = 2;
  localparam int SEG_W   = 8;
  localparam int SEL_W   = 12;
  localparam int BLINK_W = 16;
  localparam int APB_W   = 32;
  localparam int ADDR_W  = 3;

  // Register indexes of the configuration port.
  localparam logic REG_BLINK_PERIOD = 1'b0;
  localparam logic REG_ACTIVE_LOW   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE    = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_BLINK_ON  = 3'd2,
    CMD_BLINK_OFF = 3'd3,
    CMD_TICK      = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_BAD_FIELD = 2'd2,
    ST_NO_ROOM   = 2'd3
  } status_e;

  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic             ok;
    logic [SEG_W-1:0] pattern;
  } glyph_t;

  // Decodes an ASCII digit or a space into a segment pattern.
  function automatic glyph_t decode_char(input logic [CHAR_W-1:0] ch);
    glyph_t g;
    g.ok      = 1'b1;
    g.pattern = SEG_BLANK;
    case (ch)
      8'h30:   g.pattern = 8'h3f;
      8'h31:   g.pattern = 8'h06;
      8'h32:   g.pattern = 8'h5b;
      8'h33:   g.pattern = 8'h4f;
      8'h34:   g.pattern = 8'h66;
      8'h35:   g.pattern = 8'h6d;
      8'h36:   g.pattern = 8'h7d;
      8'h37:   g.pattern = 8'h07;
      8'h38:   g.pattern = 8'h7f;
      8'h39:   g.pattern = 8'h6f;
      CHAR_SPACE: g.pattern = SEG_BLANK;
      default: g.ok = 1'b0;
    endcase
    return g;
  endfunction

endpackage

@@ design/seven_segment_field_display_scanner.sv @@
// Top level of the multiplexed seven-segment field display scanner.
// Field bookkeeping, blink timing, scan control and the segment store memory.
// Depends on segscan_pkg.
//
//  Channel   | Signals                                          | Direction
//  ----------+--------------------------------------------------+----------
//  request   | start_i, busy_o, cmd_i, field_sel_i, digit_pos_i,| in
//            | char_code_i, field_len_i                         |
//  result    | done_o, status_o, new_field_o, segments_o,       | out
//            | digit_select_o                                   |
//  config    | psel, penable, pwrite, paddr, pwdata, prdata,    | in/out
//            | pready                                           |
//
// A request is taken when start_i is high and busy_o is low. Create, write
// and blink requests return their result as a strobe on done_o in the
// cycle after the request, and busy_o never rises. A refresh tick reads the
// segment store, a synchronous memory with a registered read port, so busy_o
// is high for the one cycle in which the read data comes back, and the
// result strobes in the cycle after that. A new request may be taken while
// a result is on the outputs. The receiver cannot stall.
// After reset every digit reads blank through per-digit valid bits, so no
// clearing pass is needed; the block is ready as soon as reset is released.
module seven_segment_field_display_scanner
  import segscan_pkg::*;
#(
  parameter int DIGIT_COUNT = 12,
  parameter int FIELD_COUNT = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [FSEL_W-1:0]   field_sel_i,
  input  logic [POS_W-1:0]    digit_pos_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [LEN_W-1:0]    field_len_i,
  output logic                done_o,
  output logic [STAT_W-1:0]   status_o,
  output logic [FSEL_W-1:0]   new_field_o,
  output logic [SEG_W-1:0]    segments_o,
  output logic [SEL_W-1:0]    digit_select_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [APB_W-1:0]    pwdata,
  output logic [APB_W-1:0]    prdata,
  output logic                pready
);

  localparam int IDX_W  = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int MADE_W = $clog2(FIELD_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_COUNT - 1);

  // Configuration registers.
  logic [BLINK_W-1:0] blink_period_q;
  logic               active_low_q;
  logic               cfg_wr;

  // Field table. Each entry is read at its own place, except for the single
  // lookup of the addressed field below.
  logic [LEN_W-1:0]   field_base_q [FIELD_COUNT];
  logic [LEN_W-1:0]   field_base_d [FIELD_COUNT];
  logic [LEN_W-1:0]   field_len_q  [FIELD_COUNT];
  logic [LEN_W-1:0]   field_len_d  [FIELD_COUNT];
  logic [FIELD_COUNT-1:0] field_blink_q, field_blink_d;
  logic [MADE_W-1:0]  fields_made_q, fields_made_d;
  logic [LEN_W-1:0]   digits_used_q, digits_used_d;

  // Scan and blink timing.
  logic [IDX_W-1:0]   scan_idx_q, scan_idx_d;
  logic [BLINK_W-1:0] blink_cnt_q, blink_cnt_d;
  logic               blink_off_q, blink_off_d;

  // Tick in flight: the memory read was issued at the request edge.
  logic               tick_pend_q, tick_pend_d;
  logic               tick_blank_q, tick_blank_d;
  logic [IDX_W-1:0]   tick_idx_q;

  // Segment store memory with per-digit valid bits that reset clears.
  logic [SEG_W-1:0]       seg_mem [DIGIT_COUNT];
  logic [DIGIT_COUNT-1:0] seg_valid_q;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [SEG_W-1:0]       mem_wdata;
  logic [SEG_W-1:0]       rd_data_q;
  logic                   rd_valid_q;

  // Result register.
  logic               done_q, done_d;
  logic [STAT_W-1:0]  status_q, status_d;
  logic [FSEL_W-1:0]  new_field_q, new_field_d;
  logic [SEG_W-1:0]   segments_q, segments_d;
  logic [SEL_W-1:0]   digit_sel_q, digit_sel_d;
  logic               out_tick_q;

  logic               accept;
  logic               known;
  logic [LEN_W-1:0]   sel_base;
  logic [LEN_W-1:0]   sel_len;
  logic               scan_blinks;
  logic               any_blink;
  logic [LEN_W:0]     room_sum;
  logic [LEN_W:0]     wr_at;
  logic [BLINK_W-1:0] blink_cnt_inc;
  logic [SEG_W-1:0]   tick_seg;
  logic [SEL_W-1:0]   tick_sel;
  glyph_t             glyph;

  assign accept = start_i & ~tick_pend_q;
  assign busy_o = tick_pend_q;
  assign glyph  = decode_char(char_code_i);

  // Configuration port: writes complete in the access phase, reads return
  // the register value.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_period_q <= '0;
      active_low_q   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BLINK_PERIOD: blink_period_q <= pwdata[BLINK_W-1:0];
        REG_ACTIVE_LOW:   active_low_q   <= pwdata[0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BLINK_PERIOD: prdata = {{(APB_W-BLINK_W){1'b0}}, blink_period_q};
      REG_ACTIVE_LOW:   prdata = {{(APB_W-1){1'b0}}, active_low_q};
      default:          prdata = '0;
    endcase
  end

  // Lookup of the addressed field, and the per-field checks of the scan digit.
  always_comb begin
    sel_base    = '0;
    sel_len     = '0;
    scan_blinks = 1'b0;
    any_blink   = 1'b0;
    known       = int'(field_sel_i) < int'(fields_made_q);
    for (int f = 0; f < FIELD_COUNT; f++) begin
      if (int'(field_sel_i) == f) begin
        sel_base = field_base_q[f];
        sel_len  = field_len_q[f];
      end
      if (f < int'(fields_made_q)) begin
        any_blink = any_blink | field_blink_q[f];
        if ((LEN_W+1)'(scan_idx_q) >= {1'b0, field_base_q[f]} &&
            (LEN_W+1)'(scan_idx_q) < ({1'b0, field_base_q[f]} + {1'b0, field_len_q[f]})) begin
          scan_blinks = scan_blinks | field_blink_q[f];
        end
      end
    end
  end

  assign room_sum      = {1'b0, digits_used_q} + {1'b0, field_len_i};
  assign wr_at         = {1'b0, sel_base} + {1'b0, digit_pos_i};
  assign blink_cnt_inc = blink_cnt_q + BLINK_W'(1);

  // Tick result from the registered memory read.
  always_comb begin
    tick_seg = rd_valid_q ? rd_data_q : SEG_BLANK;
    if (tick_blank_q) begin
      tick_seg = SEG_BLANK;
    end
    tick_sel = SEL_W'(1) << tick_idx_q;
    if (active_low_q) begin
      tick_seg = ~tick_seg;
      tick_sel = ~tick_sel;
    end
  end

  // Request decode: next state of the field table, timing and results.
  always_comb begin
    field_base_d  = field_base_q;
    field_len_d   = field_len_q;
    field_blink_d = field_blink_q;
    fields_made_d = fields_made_q;
    digits_used_d = digits_used_q;
    scan_idx_d    = scan_idx_q;
    blink_cnt_d   = blink_cnt_q;
    blink_off_d   = blink_off_q;
    tick_pend_d   = 1'b0;
    tick_blank_d  = tick_blank_q;
    mem_we        = 1'b0;
    mem_waddr     = wr_at[IDX_W-1:0];
    mem_wdata     = glyph.pattern;
    done_d        = 1'b0;
    status_d      = ST_OK;
    new_field_d   = '0;
    segments_d    = '0;
    digit_sel_d   = '0;

    if (tick_pend_q) begin
      done_d      = 1'b1;
      segments_d  = tick_seg;
      digit_sel_d = tick_sel;
    end

    if (accept) begin
      done_d = (cmd_i != CMD_TICK);
      unique case (cmd_i)
        CMD_CREATE: begin
          if (field_len_i == '0) begin
            status_d = ST_BAD_FIELD;
          end else if (int'(fields_made_q) >= FIELD_COUNT ||
                       int'(room_sum) > DIGIT_COUNT) begin
            status_d = ST_NO_ROOM;
          end else begin
            for (int f = 0; f < FIELD_COUNT; f++) begin
              if (int'(fields_made_q) == f) begin
                field_base_d[f]  = digits_used_q;
                field_len_d[f]   = field_len_i;
                field_blink_d[f] = 1'b0;
              end
            end
            new_field_d   = FSEL_W'(fields_made_q);
            fields_made_d = fields_made_q + MADE_W'(1);
            digits_used_d = room_sum[LEN_W-1:0];
          end
        end
        CMD_WRITE: begin
          if (!known || digit_pos_i >= sel_len) begin
            status_d = ST_BAD_FIELD;
          end else if (!glyph.ok) begin
            status_d = ST_BAD_CHAR;
          end else begin
            mem_we = 1'b1;
          end
        end
        CMD_BLINK_ON: begin
          if (!known) begin
            status_d = ST_BAD_FIELD;
          end else begin
            for (int f = 0; f < FIELD_COUNT; f++) begin
              if (int'(field_sel_i) == f) begin
                field_blink_d[f] = 1'b1;
              end
            end
            blink_cnt_d = '0;
          end
        end
        CMD_BLINK_OFF: begin
          if (!known) begin
            status_d = ST_BAD_FIELD;
          end else begin
            for (int f = 0; f < FIELD_COUNT; f++) begin
              if (int'(field_sel_i) == f) begin
                field_blink_d[f] = 1'b0;
              end
            end
            blink_off_d = 1'b0;
          end
        end
        CMD_TICK: begin
          tick_pend_d  = 1'b1;
          tick_blank_d = blink_off_q & scan_blinks;
          scan_idx_d   = (scan_idx_q == LAST_IDX) ? '0 : scan_idx_q + IDX_W'(1);
          if (any_blink) begin
            if (blink_cnt_inc >= blink_period_q) begin
              blink_cnt_d = '0;
              blink_off_d = ~blink_off_q;
            end else begin
              blink_cnt_d = blink_cnt_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int f = 0; f < FIELD_COUNT; f++) begin
        field_base_q[f] <= '0;
        field_len_q[f]  <= '0;
      end
      field_blink_q <= '0;
      fields_made_q <= '0;
      digits_used_q <= '0;
      scan_idx_q    <= '0;
      blink_cnt_q   <= '0;
      blink_off_q   <= 1'b0;
      tick_pend_q   <= 1'b0;
      seg_valid_q   <= '0;
      done_q        <= 1'b0;
    end else begin
      field_base_q  <= field_base_d;
      field_len_q   <= field_len_d;
      field_blink_q <= field_blink_d;
      fields_made_q <= fields_made_d;
      digits_used_q <= digits_used_d;
      scan_idx_q    <= scan_idx_d;
      blink_cnt_q   <= blink_cnt_d;
      blink_off_q   <= blink_off_d;
      tick_pend_q   <= tick_pend_d;
      done_q        <= done_d;
      if (mem_we) begin
        seg_valid_q[mem_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    tick_blank_q <= tick_blank_d;
    if (accept) begin
      tick_idx_q <= scan_idx_q;
    end
    status_q    <= status_d;
    new_field_q <= new_field_d;
    segments_q  <= segments_d;
    digit_sel_q <= digit_sel_d;
    out_tick_q  <= tick_pend_q;
  end

  // Segment store: one write port, one registered read port. A write and
  // a read never share a cycle, since both happen only on an accepted request:
  // the write for a write command, the read for a tick command.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seg_mem[mem_waddr] <= mem_wdata;
    end
    if (accept && cmd_i == CMD_TICK) begin
      rd_data_q  <= seg_mem[scan_idx_q];
      rd_valid_q <= seg_valid_q[scan_idx_q];
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign new_field_o    = new_field_q;
  assign segments_o     = segments_q;
  assign digit_select_o = digit_sel_q;

  // A tick read is outstanding for exactly one cycle.
  a_tick_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_pend_q |=> !tick_pend_q)
    else $error("tick read outstanding for more than one cycle");

  // Every finished tick produces a result in the next cycle.
  a_tick_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_pend_q |=> done_o)
    else $error("tick result missing");

  // A tick result enables exactly one digit.
  a_sel_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_tick_q) |-> $onehot(digit_select_o ^ {SEL_W{active_low_q}}))
    else $error("digit select not one-hot");

  // Scan position and digit allocation stay inside the display.
  a_scan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(scan_idx_q) < DIGIT_COUNT) && (int'(digits_used_q) <= DIGIT_COUNT))
    else $error("scan index or digit count out of range");

  // A write to the store only happens when no tick read is in flight.
  a_no_write_in_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_pend_q |-> !mem_we)
    else $error("store written while a read is outstanding");

endmodule

@@ tb/segscan_result_checker.sv @@
// Result checker for the seven-segment field display scanner testbench.
// Watches the request, result and register channels, predicts each result and compares.
// Depends on segscan_pkg.
module segscan_result_checker
  import segscan_pkg::*;
#(
  parameter int DIGIT_COUNT = 12,
  parameter int FIELD_COUNT = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [FSEL_W-1:0] field_sel_i,
  input  logic [POS_W-1:0]  digit_pos_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [LEN_W-1:0]  field_len_i,
  input  logic              done_o,
  input  logic [STAT_W-1:0] status_o,
  input  logic [FSEL_W-1:0] new_field_o,
  input  logic [SEG_W-1:0]  segments_o,
  input  logic [SEL_W-1:0]  digit_select_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]  pwdata,
  input  logic [APB_W-1:0]  prdata,
  input  logic              pready,
  output int                pending_o,
  output int                mismatches_o,
  output int                checked_o
);

  typedef struct packed {
    status_e           status;
    logic [FSEL_W-1:0] new_field;
    logic [SEG_W-1:0]  segments;
    logic [SEL_W-1:0]  digit_select;
  } scan_result_t;

  // Segment patterns of the numerals, numeral 0 in the lowest byte.
  localparam logic [10*SEG_W-1:0] NUMERAL_SEGMENTS =
    {8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};

  // Shadow of the display state and of the two registers.
  logic [SEG_W-1:0]   shown_pattern [DIGIT_COUNT];
  int                 field_first [FIELD_COUNT];
  int                 field_digits [FIELD_COUNT];
  logic               field_blinks [FIELD_COUNT];
  int                 made_fields;
  int                 taken_digits;
  int                 scan_digit;
  logic [BLINK_W-1:0] blink_ticks;
  logic               blink_dark;
  logic [BLINK_W-1:0] blink_period;
  logic               drive_inverted;

  scan_result_t awaited_results [$];
  int           mismatch_total;
  int           checked_total;

  task automatic note_mismatch(input string what);
    if (mismatch_total < 10) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatch_total++;
  endtask

  // Applies one request to the shadow state and returns the result it causes.
  function automatic scan_result_t predict_response(
    input logic [CMD_W-1:0]  cmd,
    input logic [FSEL_W-1:0] fsel,
    input logic [POS_W-1:0]  pos,
    input logic [CHAR_W-1:0] ch,
    input logic [LEN_W-1:0]  len
  );
    scan_result_t r;
    logic         known;
    logic         hit;
    logic         any;
    int           at;
    r.status       = ST_OK;
    r.new_field    = '0;
    r.segments     = '0;
    r.digit_select = '0;
    known = int'(fsel) < made_fields;
    hit   = 1'b0;
    any   = 1'b0;
    case (cmd)
      CMD_CREATE: begin
        if (len == '0) begin
          r.status = ST_BAD_FIELD;
        end else if (made_fields >= FIELD_COUNT || taken_digits + int'(len) > DIGIT_COUNT) begin
          r.status = ST_NO_ROOM;
        end else begin
          field_first[made_fields]  = taken_digits;
          field_digits[made_fields] = int'(len);
          field_blinks[made_fields] = 1'b0;
          r.new_field  = made_fields[FSEL_W-1:0];
          made_fields  = made_fields + 1;
          taken_digits = taken_digits + int'(len);
        end
      end
      CMD_WRITE: begin
        if (!known || int'(pos) >= field_digits[fsel]) begin
          r.status = ST_BAD_FIELD;
        end else if (ch != CHAR_SPACE && (ch < CHAR_ZERO || ch > CHAR_NINE)) begin
          r.status = ST_BAD_CHAR;
        end else begin
          at = field_first[fsel] + int'(pos);
          if (ch == CHAR_SPACE) begin
            shown_pattern[at] = SEG_BLANK;
          end else begin
            shown_pattern[at] = NUMERAL_SEGMENTS[int'(ch - CHAR_ZERO)*SEG_W +: SEG_W];
          end
        end
      end
      CMD_BLINK_ON: begin
        if (!known) begin
          r.status = ST_BAD_FIELD;
        end else begin
          field_blinks[fsel] = 1'b1;
          blink_ticks        = '0;
        end
      end
      CMD_BLINK_OFF: begin
        if (!known) begin
          r.status = ST_BAD_FIELD;
        end else begin
          field_blinks[fsel] = 1'b0;
          blink_dark         = 1'b0;
        end
      end
      CMD_TICK: begin
        for (int f = 0; f < made_fields; f++) begin
          if (field_blinks[f]) any = 1'b1;
          if (scan_digit >= field_first[f] && scan_digit < field_first[f] + field_digits[f]) begin
            hit = field_blinks[f];
          end
        end
        r.segments     = (blink_dark && hit) ? SEG_BLANK : shown_pattern[scan_digit];
        r.digit_select = {{(SEL_W-1){1'b0}}, 1'b1} << scan_digit;
        if (drive_inverted) begin
          r.segments     = ~r.segments;
          r.digit_select = ~r.digit_select;
        end
        scan_digit = (scan_digit + 1 >= DIGIT_COUNT) ? 0 : scan_digit + 1;
        if (any) begin
          blink_ticks = blink_ticks + 1'b1;
          if (blink_ticks >= blink_period) begin
            blink_ticks = '0;
            blink_dark  = ~blink_dark;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scan_result_t       want;
    logic [APB_W-1:0]   reg_value;
    if (!rst_ni) begin
      for (int i = 0; i < DIGIT_COUNT; i++) shown_pattern[i] = SEG_BLANK;
      for (int f = 0; f < FIELD_COUNT; f++) begin
        field_first[f]  = 0;
        field_digits[f] = 0;
        field_blinks[f] = 1'b0;
      end
      made_fields    = 0;
      taken_digits   = 0;
      scan_digit     = 0;
      blink_ticks    = '0;
      blink_dark     = 1'b0;
      blink_period   = '0;
      drive_inverted = 1'b0;
      awaited_results.delete();
      mismatch_total = 0;
      checked_total  = 0;
      pending_o    <= 0;
      mismatches_o <= 0;
      checked_o    <= 0;
    end else begin
      // Results first: a request taken at this edge cannot answer before the next one.
      if (done_o) begin
        if (awaited_results.size() == 0) begin
          note_mismatch($sformatf("unrequested result status %0d new_field %0d seg %02h sel %03h",
                                  status_o, new_field_o, segments_o, digit_select_o));
        end else begin
          want = awaited_results.pop_front();
          checked_total++;
          if (status_o !== want.status || new_field_o !== want.new_field ||
              segments_o !== want.segments || digit_select_o !== want.digit_select) begin
            note_mismatch($sformatf(
              "result %0d expected st %0d nf %0d seg %02h sel %03h, got st %0d nf %0d seg %02h sel %03h",
              checked_total, want.status, want.new_field, want.segments, want.digit_select,
              status_o, new_field_o, segments_o, digit_select_o));
          end
        end
      end
      if (psel && penable && pready) begin
        reg_value = (paddr[ADDR_W-1:2] == REG_BLINK_PERIOD) ?
                    APB_W'(blink_period) : APB_W'(drive_inverted);
        if (pwrite) begin
          case (paddr[ADDR_W-1:2])
            REG_BLINK_PERIOD: blink_period   = pwdata[BLINK_W-1:0];
            REG_ACTIVE_LOW:   drive_inverted = pwdata[0];
            default: ;
          endcase
        end else if (prdata !== reg_value) begin
          note_mismatch($sformatf("register read at %0h expected %0h, got %0h",
                                  paddr, reg_value, prdata));
        end
      end
      if (start_i && !busy_o) begin
        awaited_results.push_back(predict_response(cmd_i, field_sel_i, digit_pos_i,
                                                   char_code_i, field_len_i));
      end
      pending_o    <= awaited_results.size();
      mismatches_o <= mismatch_total;
      checked_o    <= checked_total;
    end
  end

endmodule

@@ tb/tb_seven_segment_field_display_scanner.sv @@
// Testbench top for the seven-segment field display scanner: clock, reset,
// request and register stimulus, and the final verdict. Depends on segscan_pkg,
// the scanner RTL and segscan_result_checker.
module tb_seven_segment_field_display_scanner
  import segscan_pkg::*;
();

  localparam int DIGITS         = 12;
  localparam int FIELDS         = 4;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_REQUESTS = 125;
  localparam int MAX_GAP        = 18;
  localparam int DRAIN_CYCLES   = 4;
  localparam int CYCLE_LIMIT    = 200000;

  // Command codes the block does not define; they must answer a plain OK.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [CMD_W-1:0]  cmd_i;
  logic [FSEL_W-1:0] field_sel_i;
  logic [POS_W-1:0]  digit_pos_i;
  logic [CHAR_W-1:0] char_code_i;
  logic [LEN_W-1:0]  field_len_i;
  logic              done_o;
  logic [STAT_W-1:0] status_o;
  logic [FSEL_W-1:0] new_field_o;
  logic [SEG_W-1:0]  segments_o;
  logic [SEL_W-1:0]  digit_select_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_W-1:0]  pwdata;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  int pending_count;
  int mismatch_count;
  int checked_count;
  int cycle_count = 0;
  int request_count;
  int tick_count;
  int burst_left;

  // Field lengths that the directed part builds; random writes aim inside them.
  int layout_len [FIELDS];

  seven_segment_field_display_scanner #(
    .DIGIT_COUNT(DIGITS),
    .FIELD_COUNT(FIELDS)
  ) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .cmd_i(cmd_i), .field_sel_i(field_sel_i), .digit_pos_i(digit_pos_i),
    .char_code_i(char_code_i), .field_len_i(field_len_i),
    .done_o(done_o), .status_o(status_o), .new_field_o(new_field_o),
    .segments_o(segments_o), .digit_select_o(digit_select_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  segscan_result_checker #(
    .DIGIT_COUNT(DIGITS),
    .FIELD_COUNT(FIELDS)
  ) u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .cmd_i(cmd_i), .field_sel_i(field_sel_i), .digit_pos_i(digit_pos_i),
    .char_code_i(char_code_i), .field_len_i(field_len_i),
    .done_o(done_o), .status_o(status_o), .new_field_o(new_field_o),
    .segments_o(segments_o), .digit_select_o(digit_select_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pending_o(pending_count), .mismatches_o(mismatch_count), .checked_o(checked_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Idle cycles before the next request. Every so often a burst of
  // back-to-back requests starts, so that the block also sees no gaps at all.
  function automatic int draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(15, 40);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Presents one request and returns once it is taken and busy_o is low.
  // start_i is left high on return; the next call either lowers it for a gap or
  // reuses it for the next request, so it never gets two assignments in one step.
  task automatic send_request(
    input logic [CMD_W-1:0]  cmd,
    input logic [FSEL_W-1:0] fsel,
    input logic [POS_W-1:0]  pos,
    input logic [CHAR_W-1:0] ch,
    input logic [LEN_W-1:0]  len
  );
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    cmd_i       <= cmd;
    field_sel_i <= fsel;
    digit_pos_i <= pos;
    char_code_i <= ch;
    field_len_i <= len;
    // A refresh tick holds busy_o for one cycle while the store read returns.
    do @(posedge clk_i); while (busy_o);
    request_count++;
    if (cmd == CMD_TICK) tick_count++;
  endtask

  // Random request mix. All four fields exist by now, so most writes are
  // well formed and land inside a field; the rest carry arbitrary positions
  // and characters. Unused fields of every request are random as well.
  task automatic send_random_request();
    int                pick;
    int                f;
    logic [FSEL_W-1:0] fsel;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  len;
    pick = $urandom_range(0, 99);
    fsel = FSEL_W'($urandom);
    pos  = POS_W'($urandom);
    ch   = CHAR_W'($urandom);
    len  = LEN_W'($urandom);
    if (pick < 40) begin
      send_request(CMD_TICK, fsel, pos, ch, len);
    end else if (pick < 76) begin
      if ($urandom_range(0, 7) != 0) begin
        f    = $urandom_range(0, FIELDS - 1);
        fsel = FSEL_W'(f);
        pos  = POS_W'($urandom_range(0, layout_len[f] - 1));
        ch   = ($urandom_range(0, 10) == 10) ? CHAR_SPACE :
               CHAR_W'(CHAR_ZERO + $urandom_range(0, 9));
      end
      send_request(CMD_WRITE, fsel, pos, ch, len);
    end else if (pick < 86) begin
      send_request(CMD_BLINK_ON, fsel, pos, ch, len);
    end else if (pick < 93) begin
      send_request(CMD_BLINK_OFF, fsel, pos, ch, len);
    end else if (pick < 96) begin
      // The display is full, so these creates must all be refused.
      send_request(CMD_CREATE, fsel, pos, ch, len);
    end else begin
      send_request(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                   fsel, pos, ch, len);
    end
  endtask

  // Drops start_i and waits until every request has been answered.
  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  // Writes a register and reads it back in two back-to-back transfers;
  // the checker follows the write and compares the read data.
  task automatic program_register(input logic idx, input logic [APB_W-1:0] value);
    for (int op = 0; op < 2; op++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= (op == 0);
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [BLINK_W-1:0] period;
    logic               invert;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    cmd_i         = '0;
    field_sel_i   = '0;
    digit_pos_i   = '0;
    char_code_i   = '0;
    field_len_i   = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    request_count = 0;
    tick_count    = 0;
    burst_left    = 0;
    layout_len    = '{3, 5, 1, 3};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Requests on fields that do not exist yet, and a tick of the blank display.
    send_request(CMD_WRITE, 2'd0, 4'd0, CHAR_ZERO + 8'd5, 4'd0);
    send_request(CMD_BLINK_ON, 2'd3, 4'd0, 8'h00, 4'd0);
    send_request(CMD_BLINK_OFF, 2'd0, 4'd0, 8'h00, 4'd0);
    send_request(CMD_TICK, 2'd0, 4'd0, 8'h00, 4'd0);

    // Field creation: zero length, too long for an empty display, then the
    // layout 3/5/1/3 with refused creates in between and one when all fields exist.
    send_request(CMD_CREATE, 2'd0, 4'd0, 8'h00, 4'd0);
    send_request(CMD_CREATE, 2'd0, 4'd0, 8'h00, 4'd15);
    send_request(CMD_CREATE, 2'd0, 4'd0, 8'h00, 4'd3);
    send_request(CMD_CREATE, 2'd0, 4'd0, 8'h00, 4'd12);
    send_request(CMD_CREATE, 2'd0, 4'd0, 8'h00, 4'd5);
    send_request(CMD_CREATE, 2'd0, 4'd0, 8'h00, 4'd1);
    send_request(CMD_CREATE, 2'd0, 4'd0, 8'h00, 4'd4);
    send_request(CMD_CREATE, 2'd0, 4'd0, 8'h00, 4'd3);
    send_request(CMD_CREATE, 2'd0, 4'd0, 8'h00, 4'd1);

    // Writes: good digits and a space, positions past the field end, and
    // characters just outside the digit range and at the top of the code.
    send_request(CMD_WRITE, 2'd0, 4'd0, CHAR_ZERO, 4'd0);
    send_request(CMD_WRITE, 2'd3, 4'd2, CHAR_NINE, 4'd0);
    send_request(CMD_WRITE, 2'd1, 4'd4, CHAR_SPACE, 4'd0);
    send_request(CMD_WRITE, 2'd2, 4'd1, CHAR_ZERO + 8'd7, 4'd0);
    send_request(CMD_WRITE, 2'd1, 4'd15, CHAR_ZERO + 8'd3, 4'd0);
    send_request(CMD_WRITE, 2'd0, 4'd1, CHAR_ZERO - 8'd1, 4'd0);
    send_request(CMD_WRITE, 2'd0, 4'd2, CHAR_NINE + 8'd1, 4'd0);
    send_request(CMD_WRITE, 2'd2, 4'd0, 8'hff, 4'd0);

    // Blink on and off around a tick, then the unused command codes.
    send_request(CMD_BLINK_ON, 2'd1, 4'd0, 8'h00, 4'd0);
    send_request(CMD_TICK, 2'd0, 4'd0, 8'h00, 4'd0);
    send_request(CMD_BLINK_OFF, 2'd1, 4'd0, 8'h00, 4'd0);
    send_request(CMD_SPARE_LAST, 2'd3, 4'd15, 8'hff, 4'd15);
    send_request(CMD_SPARE_FIRST, 2'd0, 4'd0, 8'h00, 4'd0);

    // Random phases, each under its own blink period and drive polarity,
    // the extremes of both registers among them.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       begin period = 16'd0;     invert = 1'b1; end
        1:       begin period = 16'd3;     invert = 1'b0; end
        2:       begin period = 16'hffff;  invert = 1'b1; end
        3:       begin period = 16'd1;     invert = 1'b0; end
        4:       begin period = BLINK_W'($urandom_range(2, 12)); invert = 1'b1; end
        default: begin period = BLINK_W'($urandom_range(0, 6));  invert = 1'b0; end
      endcase
      settle();
      program_register(REG_BLINK_PERIOD, APB_W'(period));
      program_register(REG_ACTIVE_LOW, APB_W'(invert));
      repeat (PHASE_REQUESTS) send_random_request();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests, %0d of them refresh ticks, under %0d register settings;",
             request_count, tick_count, RANDOM_PHASES + 1);
    $display("%0d results compared, %0d mismatches.", checked_count, mismatch_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
